[design/pba_pkg.sv]
// Shared definitions for the page bitmap allocator: sizes, action codes,
// sequencer states and the bitmap RAM request struct.
// No dependencies.
`default_nettype none

package pba_pkg;

    // Number of pages tracked by the bitmap.
    localparam int PAGE_COUNT   = 32768;
    localparam int BITMAP_WORDS = (PAGE_COUNT + 31) / 32;
    localparam int WORD_AW      = $clog2(BITMAP_WORDS);
    localparam int PAGE_AW      = WORD_AW + 5;

    // Fixed widths of the item fields.
    localparam int PAGE_W   = 15;
    localparam int ACTION_W = 2;

    localparam logic [31:0]        PAGE_LIMIT = 32'(PAGE_COUNT);
    localparam logic [WORD_AW-1:0] LAST_WORD  = WORD_AW'(BITMAP_WORDS - 1);
    localparam logic [31:0]        FULL_WORD  = 32'hFFFF_FFFF;

    // Action codes carried by an input item.
    localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_UNMARK = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MODIFY,
        ST_SCAN,
        ST_RESP
    } state_t;

    // One write and one read request to the bitmap RAM per cycle.
    typedef struct packed {
        logic               we;
        logic [WORD_AW-1:0] waddr;
        logic [31:0]        wdata;
        logic               re;
        logic [WORD_AW-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

[design/pba_bitmap_ram.sv]
// Bitmap storage: one 32-bit word per 32 pages, one write and one read port,
// registered read data. Depends on pba_pkg.
`default_nettype none

module pba_bitmap_ram (
    input  wire logic              aclk,
    input  wire pba_pkg::ram_req_t req,
    output logic [31:0]            rdata
);
    import pba_pkg::*;

    logic [31:0] mem [BITMAP_WORDS];
    logic [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/pba_zero_finder.sv]
// Finds the lowest clear bit of a bitmap word with a five-level halving search.
// Depends on pba_pkg.
`default_nettype none

module pba_zero_finder (
    input  wire logic [31:0] word,
    output logic             found,
    output logic [4:0]       index
);
    import pba_pkg::*;

    always_comb begin
        logic [31:0] free_bits;
        logic [31:0] low_mask;
        free_bits = ~word;
        index     = '0;
        // At each level, if the lower half holds no free bit, step into the upper half.
        for (int k = 4; k >= 0; k--) begin
            low_mask = (32'd1 << (1 << k)) - 32'd1;
            if ((free_bits & low_mask) == '0) begin
                index[k]  = 1'b1;
                free_bits = free_bits >> (1 << k);
            end
        end
        found = (word != FULL_WORD);
    end

endmodule

`default_nettype wire

[design/page_bitmap_allocator.sv]
// Top level of the page bitmap allocator: sequencer, output register and
// instances of the bitmap RAM and the lowest-zero finder. Depends on pba_pkg.
`default_nettype none

// Channel   Direction  Ports                          Item
// s_        in         s_valid s_ready s_action s_page one action on one page
// m_        out        m_valid m_ready m_allocated_page page given by an allocate
//
// A mark or unmark item reads the bitmap word and then writes it back. An
// allocate item scans from word 0 up to the first word with a clear bit, at
// most to the last word: the scan reads one bitmap word per cycle through the
// single RAM read port and tests it with the zero finder. After reset the
// block runs a clearing pass over every bitmap word and takes no item
// meanwhile. The result waits in an output register, so a stalled m_ready
// holds only the next allocate, in ST_RESP, where no item is taken; until
// then marks and unmarks go on being accepted.

module page_bitmap_allocator (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [pba_pkg::ACTION_W-1:0] s_action,
    input  wire logic [pba_pkg::PAGE_W-1:0]  s_page,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [pba_pkg::PAGE_W-1:0]       m_allocated_page
);
    import pba_pkg::*;

    state_t              state_reg,  state_next;
    logic [WORD_AW-1:0]  clr_reg,    clr_next;
    logic [WORD_AW-1:0]  word_reg,   word_next;
    logic [4:0]          bit_reg,    bit_next;
    logic                set_reg,    set_next;
    logic [PAGE_W-1:0]   res_reg,    res_next;
    logic                m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0]   m_page_reg,  m_page_next;

    ram_req_t            ram_req;
    logic [31:0]         rd_data;
    logic                zero_found;
    logic [4:0]          zero_index;

    logic [31:0]         page_ext;
    logic                page_in_range;
    logic [WORD_AW-1:0]  page_word;
    logic [31:0]         cand_page;
    logic                cand_in_range;
    logic [31:0]         bit_mask;

    pba_bitmap_ram u_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (rd_data)
    );

    // The word under test in the scan is always the RAM's registered read data.
    pba_zero_finder u_finder (
        .word  (rd_data),
        .found (zero_found),
        .index (zero_index)
    );

    // Pages at or beyond the bitmap size are ignored by mark and unmark.
    assign page_ext      = 32'(s_page);
    assign page_in_range = (page_ext < PAGE_LIMIT);
    assign page_word     = page_ext[PAGE_AW-1:5];

    // A clear bit in the last, partly used word may lie past the last page.
    assign cand_page     = 32'({word_reg, zero_index});
    assign cand_in_range = (cand_page < PAGE_LIMIT);

    assign bit_mask = 32'd1 << bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg   <= word_next;
        bit_reg    <= bit_next;
        set_reg    <= set_next;
        res_reg    <= res_next;
        m_page_reg <= m_page_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        set_next     = set_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_page_next  = m_page_reg;
        ram_req      = '0;
        s_ready      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                // Word 0 holds the reserved pages; every other word starts free.
                ram_req.we    = 1'b1;
                ram_req.waddr = clr_reg;
                ram_req.wdata = (clr_reg == '0) ? FULL_WORD : '0;
                if (clr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (s_action)
                        ACT_MARK, ACT_UNMARK: begin
                            if (page_in_range) begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = page_word;
                                word_next     = page_word;
                                bit_next      = s_page[4:0];
                                set_next      = (s_action == ACT_MARK);
                                state_next    = ST_MODIFY;
                            end
                        end
                        ACT_ALLOC: begin
                            ram_req.re    = 1'b1;
                            ram_req.raddr = '0;
                            word_next     = '0;
                            state_next    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MODIFY: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = word_reg;
                ram_req.wdata = set_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
                state_next    = ST_IDLE;
            end
            ST_SCAN: begin
                if (zero_found) begin
                    if (cand_in_range) begin
                        ram_req.we    = 1'b1;
                        ram_req.waddr = word_reg;
                        ram_req.wdata = rd_data | (32'd1 << zero_index);
                        res_next      = cand_page[PAGE_W-1:0];
                    end else begin
                        res_next = '0;
                    end
                    state_next = ST_RESP;
                end else if (word_reg == LAST_WORD) begin
                    // Every page is in use.
                    res_next   = '0;
                    state_next = ST_RESP;
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = word_reg + 1'b1;
                    word_next     = word_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_page_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid          = m_valid_reg;
    assign m_allocated_page = m_page_reg;

endmodule

`default_nettype wire

[design/pba_checker.sv]
// Port-level checks for the page bitmap allocator, attached by a bind.
// Depends on pba_pkg and the page_bitmap_allocator top level.
`default_nettype none

module pba_checker (
    input wire logic                         aclk,
    input wire logic                         aresetn,
    input wire logic                         s_valid,
    input wire logic                         s_ready,
    input wire logic [pba_pkg::ACTION_W-1:0] s_action,
    input wire logic                         m_valid,
    input wire logic                         m_ready,
    input wire logic [pba_pkg::PAGE_W-1:0]   m_allocated_page
);
    import pba_pkg::*;

    // Reset empties the output register.
    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // An allocate item keeps the block busy for at least the scan.
    a_alloc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == ACT_ALLOC) |=> !s_ready)
        else $error("input ready right after an allocate item");

    // Mark and unmark items never produce a result.
    a_mark_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid &&
        ((s_action == ACT_MARK) || (s_action == ACT_UNMARK)) |=> !m_valid)
        else $error("result after a mark or unmark item");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_allocated_page))
        else $error("stalled result changed");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (.*);

`default_nettype wire
